// ===== design/pixel_gradient_colormap_core_macros.svh =====
// ---------------------------------------------------------------------------
// pixel gradient colormap assertion macros
// shared wrappers for the concurrent checks of the core
// ---------------------------------------------------------------------------
`ifndef PIXEL_GRADIENT_COLORMAP_CORE_MACROS_SVH
`define PIXEL_GRADIENT_COLORMAP_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pgc_pkg.sv =====
// ---------------------------------------------------------------------------
// pgc_pkg
// widths, codes and types of the pixel gradient colormap core
// ---------------------------------------------------------------------------
package pgc_pkg;

  // fixed field widths
  localparam int SAMP_W  = 32;
  localparam int POS_W   = 17;
  localparam int COMP_W  = 8;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NCH     = 3;

  // parameter defaults
  localparam int DEF_MAX_STOPS     = 8;
  localparam int DEF_FRACTION_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GREEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLUE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NODATA    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd7;

  // render mode bits
  localparam int MODE_DISCRETE = 0;
  localparam int MODE_SQUARE   = 1;
  localparam int MODE_BGRA     = 2;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // alpha values
  localparam logic [COMP_W-1:0] ALPHA_ON  = 8'd255;
  localparam logic [COMP_W-1:0] ALPHA_OFF = 8'd0;

  // normalisation outcome
  localparam logic [1:0] NK_DIV  = 2'd0;
  localparam logic [1:0] NK_ZERO = 2'd1;
  localparam logic [1:0] NK_ONE  = 2'd2;

  // lookup outcome
  localparam logic [1:0] LK_ZERO   = 2'd0;
  localparam logic [1:0] LK_DIRECT = 2'd1;
  localparam logic [1:0] LK_INTERP = 2'd2;

  // stop write carried down the pipeline
  typedef struct packed {
    logic [1:0]        ch;
    logic [2:0]        slot;
    logic [POS_W-1:0]  pos;
    logic [COMP_W-1:0] comp;
    logic              last;
  } wr_t;

  // per-item control
  typedef struct packed {
    logic pix;
    logic alpha;
    wr_t  wr;
  } ctl_t;

endpackage

// ===== design/pixel_gradient_colormap_core.sv =====
// ---------------------------------------------------------------------------
// pixel_gradient_colormap_core
// window/level gradient colormap renderer, when not stalled one pixel per cycle
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries render items (three band samples)
// and stop write items (one gradient stop of one channel). Render items give
// one result item on out_*; stop writes give none. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle, which the block does not enforce. The work is a linear
// pipeline: input register, no-data test, clamp set-up, a restoring divider
// of FRACTION_BITS stages (one quotient bit each), value, square, stop
// lookup, interpolation product, an 8-stage restoring divider and the output
// register. One item enters each cycle unless a stall holds it.
// Stop writes take effect when they pass the lookup stage, so earlier pixels
// in flight still see the old stops.
// Reset empties the pipeline, sets all stop table lengths to zero and loads
// the register defaults. When out_valid is high and out_stall is high the
// whole pipeline holds and in_stall is raised; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module pixel_gradient_colormap_core
  import pgc_pkg::*;
#(
  parameter int MAX_STOPS     = DEF_MAX_STOPS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SAMP_W-1:0]        cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic signed [SAMP_W-1:0] in_sample_red,
  input  logic signed [SAMP_W-1:0] in_sample_green,
  input  logic signed [SAMP_W-1:0] in_sample_blue,
  input  logic [1:0]               in_stop_channel,
  input  logic [2:0]               in_stop_slot,
  input  logic [POS_W-1:0]         in_stop_position,
  input  logic [COMP_W-1:0]        in_stop_component,
  input  logic                     in_stop_is_last,
  // result items
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COMP_W-1:0]        out_first,
  output logic [COMP_W-1:0]        out_second,
  output logic [COMP_W-1:0]        out_third,
  output logic [COMP_W-1:0]        out_alpha
);

  localparam int FB   = FRACTION_BITS;
  localparam int VW   = FB + 1;
  localparam int CW   = (VW > POS_W) ? VW : POS_W;
  localparam int SW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int LW   = $clog2(MAX_STOPS + 1);
  localparam int NW   = COMP_W + POS_W + 1;
  localparam int PRW  = COMP_W + POS_W;
  localparam int IQ_W = COMP_W;
  localparam int RW   = POS_W + 5;
  localparam int ST_B = 1;
  localparam int ST_C = 2;
  localparam int ST_V = ST_C + FB + 1;
  localparam int ST_Q = ST_V + 1;
  localparam int ST_L = ST_Q + 1;
  localparam int ST_M = ST_L + 1;
  localparam int ST_O = ST_M + IQ_W + 1;
  localparam int NST  = ST_O + 1;

  // configuration registers
  logic signed [SAMP_W-1:0] cfg_min_r [NCH];
  logic signed [SAMP_W-1:0] cfg_max_r [NCH];
  logic signed [SAMP_W-1:0] thr_r;
  logic [MODE_W-1:0]        mode_r;

  // pipeline control
  logic             adv;
  logic [NST-1:0]   vld_r;
  ctl_t             ctl_r [NST];
  ctl_t             ctl_in;

  // stage payloads
  logic signed [SAMP_W-1:0] a_samp_r [NCH];
  logic signed [SAMP_W-1:0] b_samp_r [NCH], b_samp_nxt [NCH];
  logic                     b_alpha_nxt;

  logic [SAMP_W-1:0] nrem_r  [FB+1][NCH], nrem_nxt  [FB+1][NCH];
  logic [SAMP_W-1:0] nspan_r [FB+1][NCH], nspan_nxt [FB+1][NCH];
  logic [FB-1:0]     nq_r    [FB+1][NCH], nq_nxt    [FB+1][NCH];
  logic [1:0]        nkind_r [FB+1][NCH], nkind_nxt [FB+1][NCH];

  logic [VW-1:0] v_r  [NCH], v_nxt  [NCH];
  logic [VW-1:0] sq_r [NCH], sq_nxt [NCH];

  logic [1:0]        l_kind_r [NCH], l_kind_nxt [NCH];
  logic [COMP_W-1:0] l_col_r  [NCH], l_col_nxt  [NCH];
  logic [COMP_W-1:0] l_c0_r   [NCH], l_c0_nxt   [NCH];
  logic [COMP_W-1:0] l_c1_r   [NCH], l_c1_nxt   [NCH];
  logic [POS_W-1:0]  l_p0_r   [NCH], l_p0_nxt   [NCH];
  logic [POS_W-1:0]  l_p1_r   [NCH], l_p1_nxt   [NCH];
  logic [POS_W-1:0]  l_v_r    [NCH], l_v_nxt    [NCH];

  logic [NW-1:0]     irem_r  [IQ_W+1][NCH], irem_nxt  [IQ_W+1][NCH];
  logic [POS_W-1:0]  iden_r  [IQ_W+1][NCH], iden_nxt  [IQ_W+1][NCH];
  logic [IQ_W-1:0]   iq_r    [IQ_W+1][NCH], iq_nxt    [IQ_W+1][NCH];
  logic [1:0]        ikind_r [IQ_W+1][NCH], ikind_nxt [IQ_W+1][NCH];
  logic [COMP_W-1:0] icol_r  [IQ_W+1][NCH], icol_nxt  [IQ_W+1][NCH];

  logic [COMP_W-1:0] o_r [NCH], o_nxt [NCH];

  // stop tables
  logic [POS_W-1:0]  tpos_r  [NCH][MAX_STOPS];
  logic [COMP_W-1:0] tcomp_r [NCH][MAX_STOPS];
  logic [LW-1:0]     tlen_r  [NCH];
  logic              tbl_we;
  ctl_t              tw;

  // handshake
  assign out_valid = vld_r[ST_O] & ctl_r[ST_O].pix;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  assign out_first  = o_r[0];
  assign out_second = o_r[1];
  assign out_third  = o_r[2];
  assign out_alpha  = ctl_r[ST_O].alpha ? ALPHA_ON : ALPHA_OFF;

  // incoming item control
  always_comb begin
    ctl_in.pix     = (in_command == CMD_RENDER);
    ctl_in.alpha   = 1'b0;
    ctl_in.wr.ch   = in_stop_channel;
    ctl_in.wr.slot = in_stop_slot;
    ctl_in.wr.pos  = in_stop_position;
    ctl_in.wr.comp = in_stop_component;
    ctl_in.wr.last = in_stop_is_last;
  end

  // stop write applied as the item leaves the square stage
  assign tw     = ctl_r[ST_Q];
  assign tbl_we = adv && vld_r[ST_Q] && (tw.pix == CMD_WRITE)
                  && (tw.wr.ch < 2'(NCH)) && (32'(tw.wr.slot) < MAX_STOPS);

  // datapath next values
  always_comb begin
    logic signed [SAMP_W-1:0] mn;
    logic signed [SAMP_W:0]   span_w, d_w;
    logic signed [SAMP_W-1:0] lo, hi, s;
    logic [SAMP_W:0]          rem2, ndiff;
    logic                     nge;
    logic [2*VW-1:0]          prod;
    logic [CW-1:0]            vx;
    logic [LW-1:0]            len;
    logic [MAX_STOPS-1:0]     ge;
    logic                     found;
    logic [SW-1:0]            fj, fj1, lidx;
    logic [POS_W-1:0]         dhi, dlo;
    logic [PRW-1:0]           pa, pb;
    logic [NW-1:0]            sden;
    logic                     ige;
    logic [POS_W-1:0]         r;
    logic [RW-1:0]            r20, d11;
    logic [COMP_W-1:0]        chv [NCH];

    // no-data test
    mn = a_samp_r[0];
    if (a_samp_r[1] < mn) mn = a_samp_r[1];
    if (a_samp_r[2] < mn) mn = a_samp_r[2];
    b_alpha_nxt = (mn > thr_r);
    for (int i = 0; i < NCH; i++) begin
      b_samp_nxt[i] = b_alpha_nxt ? a_samp_r[i] : '0;
    end

    // clamp set-up, start of normalising division
    for (int i = 0; i < NCH; i++) begin
      lo     = cfg_min_r[i];
      hi     = cfg_max_r[i];
      s      = b_samp_r[i];
      span_w = {hi[SAMP_W-1], hi} - {lo[SAMP_W-1], lo};
      d_w    = {s[SAMP_W-1], s} - {lo[SAMP_W-1], lo};
      if (hi == lo) begin
        nkind_nxt[0][i] = NK_ZERO;
      end else if (s >= hi) begin
        nkind_nxt[0][i] = NK_ONE;
      end else if (s <= lo || lo > hi) begin
        nkind_nxt[0][i] = NK_ZERO;
      end else begin
        nkind_nxt[0][i] = NK_DIV;
      end
      nrem_nxt[0][i]  = d_w[SAMP_W-1:0];
      nspan_nxt[0][i] = span_w[SAMP_W-1:0];
      nq_nxt[0][i]    = '0;
    end

    // normalising division, one quotient bit a stage
    for (int j = 1; j <= FB; j++) begin
      for (int i = 0; i < NCH; i++) begin
        rem2  = {nrem_r[j-1][i], 1'b0};
        ndiff = rem2 - {1'b0, nspan_r[j-1][i]};
        nge   = (rem2 >= {1'b0, nspan_r[j-1][i]});
        nrem_nxt[j][i]  = nge ? ndiff[SAMP_W-1:0] : rem2[SAMP_W-1:0];
        nq_nxt[j][i]    = {nq_r[j-1][i][FB-2:0], nge};
        nspan_nxt[j][i] = nspan_r[j-1][i];
        nkind_nxt[j][i] = nkind_r[j-1][i];
      end
    end

    // normalised value
    for (int i = 0; i < NCH; i++) begin
      case (nkind_r[FB][i])
        NK_ONE:  v_nxt[i] = {1'b1, {FB{1'b0}}};
        NK_DIV:  v_nxt[i] = {1'b0, nq_r[FB][i]};
        default: v_nxt[i] = '0;
      endcase
    end

    // square transfer
    for (int i = 0; i < NCH; i++) begin
      prod      = v_r[i] * v_r[i];
      sq_nxt[i] = mode_r[MODE_SQUARE] ? prod[FB +: VW] : v_r[i];
    end

    // stop lookup
    for (int i = 0; i < NCH; i++) begin
      vx  = CW'(sq_r[i]);
      len = tlen_r[i];
      for (int j = 0; j < MAX_STOPS; j++) begin
        ge[j] = (vx >= CW'(tpos_r[i][j]));
      end
      found = 1'b0;
      fj    = '0;
      for (int j = MAX_STOPS - 2; j >= 0; j--) begin
        if ((j + 1) < int'(len) && ge[j] && !ge[j+1]) begin
          found = 1'b1;
          fj    = SW'(j);
        end
      end
      fj1  = fj + SW'(1);
      lidx = SW'(len - LW'(1));
      l_p0_nxt[i]  = tpos_r[i][fj];
      l_p1_nxt[i]  = tpos_r[i][fj1];
      l_c0_nxt[i]  = tcomp_r[i][fj];
      l_c1_nxt[i]  = tcomp_r[i][fj1];
      l_v_nxt[i]   = vx[POS_W-1:0];
      l_col_nxt[i] = '0;
      if (len == '0) begin
        l_kind_nxt[i] = LK_ZERO;
      end else if (!ge[0]) begin
        l_kind_nxt[i] = LK_DIRECT;
        l_col_nxt[i]  = tcomp_r[i][0];
      end else if (ge[lidx]) begin
        l_kind_nxt[i] = LK_DIRECT;
        l_col_nxt[i]  = tcomp_r[i][lidx];
      end else if (found) begin
        l_kind_nxt[i] = mode_r[MODE_DISCRETE] ? LK_DIRECT : LK_INTERP;
        l_col_nxt[i]  = tcomp_r[i][fj];
      end else begin
        l_kind_nxt[i] = LK_ZERO;
      end
    end

    // interpolation numerator and denominator
    for (int i = 0; i < NCH; i++) begin
      dhi = l_p1_r[i] - l_v_r[i];
      dlo = l_v_r[i] - l_p0_r[i];
      pa  = l_c0_r[i] * dhi;
      pb  = l_c1_r[i] * dlo;
      irem_nxt[0][i]  = {1'b0, pa} + {1'b0, pb};
      iden_nxt[0][i]  = l_p1_r[i] - l_p0_r[i];
      iq_nxt[0][i]    = '0;
      ikind_nxt[0][i] = l_kind_r[i];
      icol_nxt[0][i]  = l_col_r[i];
    end

    // interpolation division, msb first
    for (int j = 1; j <= IQ_W; j++) begin
      for (int i = 0; i < NCH; i++) begin
        sden = NW'(iden_r[j-1][i]) << (IQ_W - j);
        ige  = (irem_r[j-1][i] >= sden);
        irem_nxt[j][i]  = ige ? (irem_r[j-1][i] - sden) : irem_r[j-1][i];
        iq_nxt[j][i]    = {iq_r[j-1][i][IQ_W-2:0], ige};
        iden_nxt[j][i]  = iden_r[j-1][i];
        ikind_nxt[j][i] = ikind_r[j-1][i];
        icol_nxt[j][i]  = icol_r[j-1][i];
      end
    end

    // rounding: up when remainder fraction reaches 0.55
    for (int i = 0; i < NCH; i++) begin
      r   = irem_r[IQ_W][i][POS_W-1:0];
      r20 = (RW'(r) << 4) + (RW'(r) << 2);
      d11 = (RW'(iden_r[IQ_W][i]) << 3) + (RW'(iden_r[IQ_W][i]) << 1)
            + RW'(iden_r[IQ_W][i]);
      case (ikind_r[IQ_W][i])
        LK_INTERP: chv[i] = iq_r[IQ_W][i] + COMP_W'(r20 >= d11);
        LK_DIRECT: chv[i] = icol_r[IQ_W][i];
        default:   chv[i] = '0;
      endcase
    end
    o_nxt[0] = mode_r[MODE_BGRA] ? chv[2] : chv[0];
    o_nxt[1] = chv[1];
    o_nxt[2] = mode_r[MODE_BGRA] ? chv[0] : chv[2];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int k = 1; k < NST; k++) begin
        if (k != ST_B) begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
      ctl_r[ST_B] <= {ctl_r[ST_B-1].pix, b_alpha_nxt, ctl_r[ST_B-1].wr};
      a_samp_r[0] <= in_sample_red;
      a_samp_r[1] <= in_sample_green;
      a_samp_r[2] <= in_sample_blue;
      b_samp_r    <= b_samp_nxt;
      nrem_r      <= nrem_nxt;
      nspan_r     <= nspan_nxt;
      nq_r        <= nq_nxt;
      nkind_r     <= nkind_nxt;
      v_r         <= v_nxt;
      sq_r        <= sq_nxt;
      l_kind_r    <= l_kind_nxt;
      l_col_r     <= l_col_nxt;
      l_c0_r      <= l_c0_nxt;
      l_c1_r      <= l_c1_nxt;
      l_p0_r      <= l_p0_nxt;
      l_p1_r      <= l_p1_nxt;
      l_v_r       <= l_v_nxt;
      irem_r      <= irem_nxt;
      iden_r      <= iden_nxt;
      iq_r        <= iq_nxt;
      ikind_r     <= ikind_nxt;
      icol_r      <= icol_nxt;
      o_r         <= o_nxt;
    end
  end

  // stop table entries
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tpos_r[tw.wr.ch][SW'(tw.wr.slot)]  <= tw.wr.pos;
      tcomp_r[tw.wr.ch][SW'(tw.wr.slot)] <= tw.wr.comp;
    end
  end

  // stop table lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        tlen_r[i] <= '0;
      end
    end else if (tbl_we && tw.wr.last) begin
      tlen_r[tw.wr.ch] <= LW'(tw.wr.slot) + LW'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        cfg_min_r[i] <= 32'sd0;
        cfg_max_r[i] <= 32'sd65535;
      end
      thr_r  <= 32'sh8000_0000;
      mode_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_RED:   cfg_min_r[0] <= cfg_data;
        CFG_MAX_RED:   cfg_max_r[0] <= cfg_data;
        CFG_MIN_GREEN: cfg_min_r[1] <= cfg_data;
        CFG_MAX_GREEN: cfg_max_r[1] <= cfg_data;
        CFG_MIN_BLUE:  cfg_min_r[2] <= cfg_data;
        CFG_MAX_BLUE:  cfg_max_r[2] <= cfg_data;
        CFG_NODATA:    thr_r        <= cfg_data;
        CFG_MODE:      mode_r       <= cfg_data[MODE_W-1:0];
        default:       mode_r       <= mode_r;
      endcase
    end
  end

endmodule

// ===== design/pgc_checker.sv =====
// ---------------------------------------------------------------------------
// pgc_checker
// port-level checks of the pixel gradient colormap core, bound to the top
// ---------------------------------------------------------------------------
`include "pixel_gradient_colormap_core_macros.svh"

module pgc_checker
  import pgc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COMP_W-1:0] out_first,
  input logic [COMP_W-1:0] out_second,
  input logic [COMP_W-1:0] out_third,
  input logic [COMP_W-1:0] out_alpha
);

  // a held result item stays offered
  `PGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped")

  // a held result item keeps its colour
  `PGC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_first) && $stable(out_second) && $stable(out_third) && $stable(out_alpha), "held item changed")

  // a stalled output freezes the pipeline, so no item may enter
  `PGC_ASSERT_NOW(a_in_block, out_valid && out_stall, in_stall, "item accepted while frozen")

  // alpha is either opaque or clear
  `PGC_ASSERT_NOW(a_alpha, out_valid, out_alpha == ALPHA_ON || out_alpha == ALPHA_OFF, "bad alpha")

  // nothing comes out straight after reset
  `PGC_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid, "item after reset")

endmodule

bind pixel_gradient_colormap_core pgc_checker u_pgc_checker (.*);
